/* hw/rtl/lcmf_pkg.sv */
`default_nettype none

package lcmf_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 16;
  localparam int BRI_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int IDLE_W   = 3;
  localparam int DIGITS   = 5;
  localparam int BCD_W    = DIGITS * 4;
  localparam int DIG_IDX_W = $clog2(DIGITS);
  localparam int CNT_W    = $clog2(VALUE_W);

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN   = 3'd0,
    OP_RPM     = 3'd1,
    OP_ERROR   = 3'd2,
    OP_RAINBOW = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_BRIGHT  = 3'd5
  } lcmf_op_t;

  localparam logic [BYTE_W-1:0] CH_MARK = 8'h21;
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
  localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CH_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CH_W    = 8'h57;
  localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
  localparam logic [BYTE_W-1:0] CH_B    = 8'h42;

  localparam logic [IDLE_W-1:0] IDLE_MARK = 3'd4;
  localparam logic [IDLE_W-1:0] IDLE_BODY = 3'd2;
  localparam logic [IDLE_W-1:0] IDLE_EOM  = 3'd0;

  localparam logic [VALUE_W-1:0] SPEED_NONE = 16'hFFFF;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] value;
  } lcmf_conv_ctl_t;

  typedef struct packed {
    logic             busy;
    logic [BCD_W-1:0] bcd;
  } lcmf_conv_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/lcmf_if.sv */
`default_nettype none

interface lcmf_cmd_if;
  import lcmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VALUE_W-1:0] rpm;
  logic [VALUE_W-1:0] speed;
  logic [BRI_W-1:0]   brightness_level;

  modport source (output valid, operation, rpm, speed, brightness_level, input ready);
  modport sink (input valid, operation, rpm, speed, brightness_level, output ready);
endinterface

interface lcmf_msg_if;
  import lcmf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] tx_byte;
  logic [IDLE_W-1:0] idle_bits_after;
  logic              end_of_message;
  logic              last_of_run;

  modport source (output valid, tx_byte, idle_bits_after, end_of_message, last_of_run,
                  input ready);
  modport sink (input valid, tx_byte, idle_bits_after, end_of_message, last_of_run,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/lcmf_bcd_conv.sv */
`default_nettype none

module lcmf_bcd_conv (
  input  logic                      clk,
  input  logic                      rst,
  input  lcmf_pkg::lcmf_conv_ctl_t  ctl,
  output lcmf_pkg::lcmf_conv_stat_t stat
);
  import lcmf_pkg::*;

  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;

  // add 3 to every digit that will overflow on the next shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctl.start) begin
      busy  <= 1'b1;
      count <= '0;
      bin   <= ctl.value;
      bcd   <= '0;
    end else if (busy) begin
      bcd   <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin   <= {bin[VALUE_W-2:0], 1'b0};
      count <= count + 1'b1;
      if (count == CNT_W'(VALUE_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.bcd  = bcd;

endmodule

`default_nettype wire

/* hw/rtl/led_command_message_framer.sv */
`default_nettype none

// Command message framer: each accepted command word produces zero, one or two
// framed ASCII messages ('!', letter, optional decimal digits, newline) as a
// stream of byte words, one word per cycle while the sink is ready, apart from
// the wait for a number's conversion. The command port is ready only between
// runs. Marker and letter go out while a shared shift-and-add-3 unit converts
// the number to decimal; an rpm update with a speed change runs two messages
// back to back. The last word of a run is held in an output register while
// the next command is taken.
module led_command_message_framer (
  input logic        clk,
  input logic        rst,
  lcmf_cmd_if.sink   cmd,
  lcmf_msg_if.source msg
);
  import lcmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_LETTER,
    S_CONV,
    S_DIGIT,
    S_NEWLINE
  } state_t;

  state_t                 state;
  logic                   ready_flag;
  logic                   error_sent;
  logic [VALUE_W-1:0]     previous_speed;
  logic [VALUE_W-1:0]     speed_hold;
  logic [BYTE_W-1:0]      letter;
  logic                   has_num;
  logic                   second;
  logic [DIG_IDX_W-1:0]   dig_idx;
  logic [DIG_IDX_W-1:0]   top_idx;

  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic [IDLE_W-1:0]      out_idle;
  logic                   out_eom;
  logic                   out_last;

  logic                   accept;
  logic                   out_free;
  logic                   word_load;
  logic                   speed_chg;
  logic                   plan_emit;
  logic [BYTE_W-1:0]      plan_letter;
  logic                   plan_has_num;
  logic                   plan_second;
  logic [3:0]             cur_digit;

  lcmf_conv_ctl_t         conv_ctl;
  lcmf_conv_stat_t        conv_stat;

  lcmf_bcd_conv u_conv (
    .clk  (clk),
    .rst  (rst),
    .ctl  (conv_ctl),
    .stat (conv_stat)
  );

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || msg.ready;
  assign word_load = out_free && (state inside {S_MARK, S_LETTER, S_DIGIT, S_NEWLINE});
  assign speed_chg = (cmd.speed != previous_speed);
  assign cur_digit = conv_stat.bcd[{dig_idx, 2'b00} +: 4];

  always_comb begin
    plan_emit    = 1'b0;
    plan_letter  = CH_C;
    plan_has_num = 1'b0;
    plan_second  = 1'b0;
    case (cmd.operation)
      OP_BEGIN: begin
        plan_emit = 1'b1;
      end
      OP_RPM: begin
        plan_emit    = ready_flag;
        plan_letter  = CH_R;
        plan_has_num = 1'b1;
        plan_second  = speed_chg;
      end
      OP_ERROR: begin
        plan_emit   = ready_flag && !error_sent;
        plan_letter = CH_E;
      end
      OP_RAINBOW: begin
        plan_emit   = ready_flag;
        plan_letter = CH_W;
      end
      OP_CLEAR: begin
        plan_emit = ready_flag;
      end
      OP_BRIGHT: begin
        plan_emit    = ready_flag;
        plan_letter  = CH_B;
        plan_has_num = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    conv_ctl.start = (accept && plan_emit && plan_has_num) ||
                     (state == S_NEWLINE && out_free && second);
    if (state == S_NEWLINE) begin
      conv_ctl.value = speed_hold;
    end else if (cmd.operation == OP_BRIGHT) begin
      conv_ctl.value = VALUE_W'(cmd.brightness_level);
    end else begin
      conv_ctl.value = cmd.rpm;
    end
  end

  // most significant nonzero digit, or the units digit for zero
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (conv_stat.bcd[i*4 +: 4] != 4'd0) begin
        top_idx = DIG_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ready_flag     <= 1'b0;
      error_sent     <= 1'b0;
      previous_speed <= SPEED_NONE;
      second         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && msg.ready && !word_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.operation)
              OP_BEGIN: begin
                ready_flag     <= 1'b1;
                previous_speed <= SPEED_NONE;
                error_sent     <= 1'b0;
              end
              OP_RPM: begin
                error_sent <= 1'b0;
                if (speed_chg) begin
                  previous_speed <= cmd.speed;
                end
              end
              OP_ERROR: begin
                error_sent <= 1'b1;
              end
              OP_CLEAR: begin
                previous_speed <= SPEED_NONE;
                error_sent     <= 1'b0;
              end
              default: ;
            endcase
            if (plan_emit) begin
              letter     <= plan_letter;
              has_num    <= plan_has_num;
              second     <= plan_second;
              speed_hold <= cmd.speed;
              state      <= S_MARK;
            end
          end
        end
        S_MARK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= CH_MARK;
            out_idle  <= IDLE_MARK;
            out_eom   <= 1'b0;
            out_last  <= 1'b0;
            state     <= S_LETTER;
          end
        end
        S_LETTER: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= letter;
            out_idle  <= IDLE_BODY;
            out_eom   <= 1'b0;
            out_last  <= 1'b0;
            state     <= has_num ? S_CONV : S_NEWLINE;
          end
        end
        S_CONV: begin
          if (!conv_stat.busy) begin
            dig_idx <= top_idx;
            state   <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= CH_ZERO + {4'd0, cur_digit};
            out_idle  <= IDLE_BODY;
            out_eom   <= 1'b0;
            out_last  <= 1'b0;
            if (dig_idx == '0) begin
              state <= S_NEWLINE;
            end else begin
              dig_idx <= dig_idx - 1'b1;
            end
          end
        end
        S_NEWLINE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte  <= CH_NL;
            out_idle  <= IDLE_EOM;
            out_eom   <= 1'b1;
            out_last  <= !second;
            if (second) begin
              second  <= 1'b0;
              letter  <= CH_S;
              has_num <= 1'b1;
              state   <= S_MARK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign msg.valid           = out_valid;
  assign msg.tx_byte         = out_byte;
  assign msg.idle_bits_after = out_idle;
  assign msg.end_of_message  = out_eom;
  assign msg.last_of_run     = out_last;

endmodule

`default_nettype wire

/* hw/rtl/lcmf_chk.sv */
`default_nettype none

module lcmf_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        msg_valid,
  input logic                        msg_ready,
  input logic [lcmf_pkg::BYTE_W-1:0] tx_byte,
  input logic [lcmf_pkg::IDLE_W-1:0] idle_bits_after,
  input logic                        end_of_message,
  input logic                        last_of_run
);
  import lcmf_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_ready |=> msg_valid && $stable(tx_byte) && $stable(last_of_run))
    else $error("stalled word changed");

  // no new command mid-run
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> !msg_valid || last_of_run)
    else $error("command taken during a run");

  a_eom: assert property (@(posedge clk) disable iff (rst)
    msg_valid && end_of_message |-> tx_byte == CH_NL && idle_bits_after == IDLE_EOM)
    else $error("bad end of message word");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    msg_valid && tx_byte == CH_MARK |-> idle_bits_after == IDLE_MARK && !end_of_message)
    else $error("bad marker word");

  a_last: assert property (@(posedge clk) disable iff (rst)
    msg_valid && last_of_run |-> end_of_message)
    else $error("run ends inside a message");

endmodule

bind led_command_message_framer lcmf_chk u_lcmf_chk (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .msg_valid       (msg.valid),
  .msg_ready       (msg.ready),
  .tx_byte         (msg.tx_byte),
  .idle_bits_after (msg.idle_bits_after),
  .end_of_message  (msg.end_of_message),
  .last_of_run     (msg.last_of_run)
);

`default_nettype wire

/* verif/lcmf_frame_checker.sv */
`timescale 1ns / 1ps

module lcmf_frame_checker (
  input  logic       clk,
  input  logic       rst,
  lcmf_cmd_if        cmd,
  lcmf_msg_if        msg,
  output int         errors,
  output int         pending
);
  import lcmf_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] tx_byte;
    logic [IDLE_W-1:0] idle;
    logic              eom;
    logic              last;
  } frame_word_t;

  frame_word_t frame_q[$];
  frame_word_t run_q[$];

  logic               began;
  logic [VALUE_W-1:0] last_speed;
  logic               error_sent;
  int                 fail_cnt = 0;
  int                 n_wait = 0;

  assign errors  = fail_cnt;
  assign pending = n_wait;

  function automatic void put_word(input logic [BYTE_W-1:0] b, input logic [IDLE_W-1:0] idle,
                                   input logic eom);
    frame_word_t w;
    w.tx_byte = b;
    w.idle    = idle;
    w.eom     = eom;
    w.last    = 1'b0;
    run_q.push_back(w);
  endfunction

  function automatic void add_message(input logic [BYTE_W-1:0] letter, input bit has_num,
                                      input logic [VALUE_W-1:0] value);
    logic [BYTE_W-1:0] digs[$];
    int v;
    if (!began) return;
    put_word(CH_MARK, IDLE_MARK, 1'b0);
    put_word(letter, IDLE_BODY, 1'b0);
    if (has_num) begin
      v = value;
      do begin
        digs.push_front(CH_ZERO + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (digs[i]) put_word(digs[i], IDLE_BODY, 1'b0);
    end
    put_word(CH_NL, IDLE_EOM, 1'b1);
  endfunction

  function automatic void predict_frames(input logic [OP_W-1:0] op,
                                         input logic [VALUE_W-1:0] rpm,
                                         input logic [VALUE_W-1:0] spd,
                                         input logic [BRI_W-1:0] bri);
    frame_word_t w;
    run_q.delete();
    case (op)
      OP_BEGIN: begin
        began = 1'b1;
        add_message(CH_C, 1'b0, '0);
        last_speed = SPEED_NONE;
        error_sent = 1'b0;
      end
      OP_RPM: begin
        error_sent = 1'b0;
        add_message(CH_R, 1'b1, rpm);
        if (spd != last_speed) begin
          add_message(CH_S, 1'b1, spd);
          last_speed = spd;
        end
      end
      OP_ERROR: begin
        if (!error_sent) begin
          add_message(CH_E, 1'b0, '0);
          error_sent = 1'b1;
        end
      end
      OP_RAINBOW: add_message(CH_W, 1'b0, '0);
      OP_CLEAR: begin
        add_message(CH_C, 1'b0, '0);
        last_speed = SPEED_NONE;
        error_sent = 1'b0;
      end
      OP_BRIGHT: add_message(CH_B, 1'b1, VALUE_W'(bri));
      default: ;
    endcase
    foreach (run_q[i]) begin
      w = run_q[i];
      w.last = (i == run_q.size() - 1);
      frame_q.push_back(w);
    end
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    frame_word_t e;
    if (rst) begin
      began      = 1'b0;
      last_speed = SPEED_NONE;
      error_sent = 1'b0;
      frame_q.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        predict_frames(cmd.operation, cmd.rpm, cmd.speed, cmd.brightness_level);
      if (msg.valid && msg.ready) begin
        if (frame_q.size() == 0) begin
          $error("tx_byte: expected no word, got %0d", msg.tx_byte);
          fail_cnt++;
        end else begin
          e = frame_q.pop_front();
          check_field("tx_byte", e.tx_byte, msg.tx_byte);
          check_field("idle_bits_after", e.idle, msg.idle_bits_after);
          check_field("end_of_message", e.eom, msg.end_of_message);
          check_field("last_of_run", e.last, msg.last_of_run);
        end
      end
    end
    n_wait = frame_q.size();
  end

endmodule

/* verif/tb_led_command_message_framer.sv */
`timescale 1ns / 1ps

module tb_led_command_message_framer;
  import lcmf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYC   = 60;
  localparam int RANDOM_ITEMS = 280;
  localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_cnt;
  int   words_due;
  int   send_idle = 36;
  int   recv_idle = 62;
  int   cycles = 0;
  logic [VALUE_W-1:0] spd_seen = '0;
  logic [VALUE_W-1:0] edge_vals[10] = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                                        16'd1000, 16'd9999, 16'd10000, 16'd65535};

  lcmf_cmd_if cmd();
  lcmf_msg_if msg();

  led_command_message_framer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .msg (msg)
  );

  lcmf_frame_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .msg     (msg),
    .errors  (fail_cnt),
    .pending (words_due)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    msg.ready = 1'b0;
    forever begin
      @(negedge clk);
      msg.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] r,
                          input logic [VALUE_W-1:0] s, input logic [BRI_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid            <= 1'b1;
    cmd.operation        <= op;
    cmd.rpm              <= r;
    cmd.speed            <= s;
    cmd.brightness_level <= b;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(4))
      0: return VALUE_W'($urandom_range(65535));
      1: return VALUE_W'($urandom_range(9));
      2: return VALUE_W'($urandom_range(999));
      3: return edge_vals[$urandom_range(9)];
      default: return VALUE_W'($urandom_range(9999));
    endcase
  endfunction

  task automatic rand_cmd(output bit counted);
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] s;
    logic [BRI_W-1:0]   b;
    pick    = $urandom_range(99);
    counted = 1'b1;
    r       = pick_value();
    s       = ($urandom_range(2) == 0) ? spd_seen : pick_value();
    b       = BRI_W'($urandom_range(255));
    if (pick < 6)       op = OP_BEGIN;
    else if (pick < 45) op = OP_RPM;
    else if (pick < 57) op = OP_ERROR;
    else if (pick < 66) op = OP_RAINBOW;
    else if (pick < 74) op = OP_CLEAR;
    else if (pick < 92) op = OP_BRIGHT;
    else begin
      op      = pick[0] ? OP_UNUSED7 : OP_UNUSED6;
      counted = 1'b0;
    end
    if (op == OP_RPM) spd_seen = s;
    send_cmd(op, r, s, b);
  endtask

  initial begin
    int n;
    bit counted;
    cmd.valid            = 1'b0;
    cmd.operation        = '0;
    cmd.rpm              = '0;
    cmd.speed            = '0;
    cmd.brightness_level = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // nothing goes out before begin
    send_cmd(OP_RPM, 16'd1234, 16'd77, 8'd0);
    send_cmd(OP_ERROR, '0, '0, '0);
    send_cmd(OP_RAINBOW, '0, '0, '0);
    send_cmd(OP_CLEAR, '0, '0, '0);
    send_cmd(OP_BRIGHT, '0, '0, 8'd9);
    send_cmd(OP_UNUSED6, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_cmd(OP_BEGIN, '0, '0, '0);
    send_cmd(OP_RPM, 16'd0, 16'd0, '0);
    send_cmd(OP_RPM, 16'd65535, 16'd65535, '0);
    send_cmd(OP_RPM, 16'd10, 16'd65535, '0);
    send_cmd(OP_ERROR, '0, '0, '0);
    send_cmd(OP_ERROR, '0, '0, '0);
    send_cmd(OP_RPM, 16'd99, 16'd65535, '0);
    send_cmd(OP_ERROR, '0, '0, '0);
    send_cmd(OP_RAINBOW, '0, '0, '0);
    send_cmd(OP_BRIGHT, '0, '0, 8'd0);
    send_cmd(OP_BRIGHT, '0, '0, 8'd255);
    send_cmd(OP_BRIGHT, '0, '0, 8'd100);
    send_cmd(OP_UNUSED7, 16'hA5A5, 16'h5A5A, 8'hAA);
    send_cmd(OP_CLEAR, '0, '0, '0);
    send_cmd(OP_ERROR, '0, '0, '0);
    send_cmd(OP_RPM, 16'd9999, 16'd10000, '0);
    send_cmd(OP_BEGIN, '0, '0, '0);
    send_cmd(OP_RPM, 16'd1, 16'd65535, '0);
    drain();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 62;
        recv_idle = 36;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      rand_cmd(counted);
      if (counted) begin
        n++;
        if (n % 70 == 0) drain();
      end
    end
    drain();

    if (fail_cnt == 0 && words_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
